[hw/rtl/pdfs_pkg.sv]
// ----------------------------------------------------------------------------
// pdfs_pkg
// Shared types and codes for the shaped PD rate law: request and response
// payloads, command and register codes, and the control group of the
// convolution unit.
// ----------------------------------------------------------------------------
package pdfs_pkg;

  // request commands
  localparam logic [1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [1:0] CMD_TAP     = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_PGAIN = 2'd0;
  localparam logic [1:0] REG_DGAIN = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;
  localparam logic [1:0] REG_TAPS  = 2'd3;

  localparam int unsigned CFG_W = 31;

  localparam logic [30:0] LIMIT_RESET = 31'd65536;
  localparam logic [6:0]  TAPS_RESET  = 7'd64;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] error_in;
    logic [5:0]         tap_index;
    logic signed [15:0] tap_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] rate_out;
    logic               clamped;
  } rsp_t;

  // control group from the sequencer to the convolution unit
  typedef struct packed {
    logic push;
    logic clear;
    logic tap_we;
  } conv_ctl_t;

endpackage

[hw/rtl/pd_fir_shaped_rate.sv]
// ----------------------------------------------------------------------------
// pd_fir_shaped_rate
// PD rate law with a causal FIR shaping filter over the PD term history.
// ----------------------------------------------------------------------------
// an error sample passes the PD term, then a walk over the fill newest
// history entries (fill from 1 to the length in use), then the output register
// one error sample at a time: no request is taken until its response is
// loaded, and a stalled earlier response holds it longer; tap loads and
// restarts are taken in the idle state and start no sequence; the walk over
// the history, one tap per cycle through the ring and tap memories, grows with fill
// reset clears gains, limit and length to their defaults and empties history
module pd_fir_shaped_rate #(
  parameter int MAX_TAPS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  pdfs_pkg::req_t                    req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output pdfs_pkg::rsp_t                    rsp,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [pdfs_pkg::CFG_W-1:0]        cfg_data
);
  import pdfs_pkg::*;

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int LEN_W = $clog2(MAX_TAPS + 1);
  localparam int ACC_W = 49 + AW;
  localparam int VW    = ACC_W - 14;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PD   = 4'b0010,
    S_CONV = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [23:0] pgain;
  logic signed [23:0] dgain;
  logic [30:0]        rate_cap;
  logic [6:0]         taps_in_use;

  logic signed [31:0] prev_error;
  logic               primed;

  logic               accept;
  logic               pd_start;
  logic               pd_done;
  logic signed [31:0] pd;
  logic signed [31:0] prev_used;
  conv_ctl_t          ctl;
  logic               conv_done;
  logic signed [ACC_W-1:0] conv_sum;
  logic [LEN_W-1:0]   len;
  logic               load_rsp;

  logic signed [VW-1:0] v;
  logic signed [VW-1:0] lim;
  logic                 over;
  logic                 under;
  rsp_t                 rsp_next;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign pd_start  = accept && (req.command == CMD_SAMPLE);
  assign prev_used = primed ? prev_error : req.error_in;

  // length in use: zero acts as one, beyond the memory acts as its depth
  always_comb begin
    if (taps_in_use == '0) begin
      len = LEN_W'(1);
    end else if (32'(taps_in_use) > MAX_TAPS) begin
      len = LEN_W'(MAX_TAPS);
    end else begin
      len = LEN_W'(taps_in_use);
    end
  end

  always_comb begin
    ctl.push   = pd_done && (state == S_PD);
    ctl.clear  = (accept && (req.command == CMD_RESTART)) ||
                 (cfg_we && (cfg_index == REG_TAPS));
    ctl.tap_we = accept && (req.command == CMD_TAP) && (32'(req.tap_index) < MAX_TAPS);
  end

  pdfs_pd_term u_pd (
    .clk   (clk),
    .rst   (rst),
    .start (pd_start),
    .kp    (pgain),
    .kd    (dgain),
    .err   (req.error_in),
    .prev  (prev_used),
    .done  (pd_done),
    .pd    (pd)
  );

  pdfs_conv #(
    .MAX_TAPS (MAX_TAPS)
  ) u_conv (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .pd_in    (pd),
    .tap_addr (AW'(req.tap_index)),
    .tap_data (req.tap_value),
    .len      (len),
    .done     (conv_done),
    .sum      (conv_sum)
  );

  // floor rescale of the sum from q25.30 to q25.16, clamp to the limit as q16.16
  assign v     = $signed(conv_sum[ACC_W-1:14]);
  assign lim   = $signed(VW'(rate_cap));
  assign over  = v > lim;
  assign under = v < -lim;

  always_comb begin
    rsp_next.clamped = over || under;
    if (over) begin
      rsp_next.rate_out = lim[31:0];
    end else if (under) begin
      rsp_next.rate_out = -lim[31:0];
    end else begin
      rsp_next.rate_out = v[31:0];
    end
  end

  assign load_rsp = (state == S_OUT) && (!rsp_valid || !rsp_stall);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (pd_start) begin
          state_next = S_PD;
        end
      end
      S_PD: begin
        if (pd_done) begin
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        if (conv_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (load_rsp) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      pgain       <= '0;
      dgain       <= '0;
      rate_cap    <= LIMIT_RESET;
      taps_in_use <= TAPS_RESET;
      prev_error  <= '0;
      primed      <= 1'b0;
    end else begin
      state <= state_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PGAIN: pgain       <= $signed(cfg_data[23:0]);
          REG_DGAIN: dgain       <= $signed(cfg_data[23:0]);
          REG_LIMIT: rate_cap    <= cfg_data[30:0];
          REG_TAPS:  taps_in_use <= cfg_data[6:0];
          default:   ;
        endcase
      end
      if (pd_start) begin
        prev_error <= req.error_in;
        primed     <= 1'b1;
      end else if (accept && (req.command == CMD_RESTART)) begin
        prev_error <= '0;
        primed     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp <= rsp_next;
    end
  end

  a_rsp_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_OUT))
    else $error("response raised outside the output state");

  a_pd_done_state: assert property (@(posedge clk) disable iff (rst)
    pd_done |-> (state == S_PD))
    else $error("pd term finished outside its wait state");

  a_conv_done_state: assert property (@(posedge clk) disable iff (rst)
    conv_done |-> (state == S_CONV))
    else $error("convolution finished outside its wait state");

  a_rsp_in_limit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp.rate_out <= $signed({1'b0, rate_cap})) &&
                   (rsp.rate_out >= -$signed({1'b0, rate_cap}))))
    else $error("response beyond the rate limit");

endmodule

[hw/rtl/pdfs_pd_term.sv]
// ----------------------------------------------------------------------------
// pdfs_pd_term
// Two-stage PD term: both gain products in the first stage, sum, floor
// rescale to Q16.16 and 32-bit saturation in the second.
// ----------------------------------------------------------------------------
module pdfs_pd_term (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [23:0] kp,
  input  logic signed [23:0] kd,
  input  logic signed [31:0] err,
  input  logic signed [31:0] prev,
  output logic               done,
  output logic signed [31:0] pd
);
  import pdfs_pkg::*;

  logic               v1;
  logic               v2;
  logic signed [55:0] prod_p;
  logic signed [56:0] prod_d;
  logic signed [32:0] diff;
  logic signed [57:0] acc;
  logic               fits;
  logic signed [31:0] pd_next;

  assign diff = err - prev;
  assign acc  = prod_p + prod_d;

  // q26.32 sum, upper bits above bit 47 must all match the sign for no overflow
  assign fits = (acc[57:47] == {11{acc[47]}});

  always_comb begin
    if (fits) begin
      pd_next = acc[47:16];
    end else if (acc[57]) begin
      pd_next = 32'sh8000_0000;
    end else begin
      pd_next = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_p <= kp * err;
      prod_d <= kd * diff;
    end
    if (v1) begin
      pd <= pd_next;
    end
  end

  assign done = v2;

endmodule

[hw/rtl/pdfs_conv.sv]
// ----------------------------------------------------------------------------
// pdfs_conv
// Ring history and kernel tap memories with a one-tap-per-cycle
// multiply-accumulate walk from the newest entry backward.
// ----------------------------------------------------------------------------
module pdfs_conv #(
  parameter int MAX_TAPS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pdfs_pkg::conv_ctl_t                  ctl,
  input  logic signed [31:0]                   pd_in,
  input  logic [(MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1)-1:0] tap_addr,
  input  logic signed [15:0]                   tap_data,
  input  logic [$clog2(MAX_TAPS + 1)-1:0]      len,
  output logic                                 done,
  output logic signed [48 + (MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1):0] sum
);
  import pdfs_pkg::*;

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int LEN_W = $clog2(MAX_TAPS + 1);
  localparam int ACC_W = 49 + AW;

  logic signed [31:0] ring_mem [MAX_TAPS];
  logic signed [15:0] tap_mem  [MAX_TAPS];

  logic [AW-1:0]           head;
  logic [LEN_W-1:0]        fill;
  logic                    busy;
  logic [AW-1:0]           rd_pos;
  logic [LEN_W-1:0]        cnt;
  logic                    rd_v;
  logic                    mul_v;
  logic signed [31:0]      ring_q;
  logic signed [15:0]      tap_q;
  logic signed [47:0]      prod;
  logic signed [ACC_W-1:0] acc;

  logic [AW-1:0]    wr_pos;
  logic [AW-1:0]    head_next;
  logic [LEN_W-1:0] fill_next;
  logic             issuing;

  assign wr_pos    = (LEN_W'(head) >= len) ? '0 : head;
  assign head_next = (LEN_W'(wr_pos) + LEN_W'(1) == len) ? '0 : wr_pos + AW'(1);
  assign fill_next = (fill < len) ? fill + LEN_W'(1) : len;
  assign issuing   = busy && (cnt < fill);
  assign done      = busy && !issuing && !rd_v && !mul_v;

  // no clearing of the ring contents: the walk only reaches the fill newest
  // entries, all written since the last clear
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      fill  <= '0;
      busy  <= 1'b0;
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
    end else begin
      rd_v  <= issuing;
      mul_v <= rd_v;
      if (ctl.clear) begin
        head <= '0;
        fill <= '0;
      end else if (ctl.push) begin
        head <= head_next;
        fill <= fill_next;
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      rd_pos <= wr_pos;
      cnt    <= '0;
      acc    <= '0;
    end else begin
      if (issuing) begin
        rd_pos <= (rd_pos == '0) ? AW'(len - LEN_W'(1)) : rd_pos - AW'(1);
        cnt    <= cnt + LEN_W'(1);
      end
      if (mul_v) begin
        acc <= acc + prod;
      end
    end
    prod <= ring_q * tap_q;
  end

  // memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      ring_mem[wr_pos] <= pd_in;
    end
    ring_q <= ring_mem[rd_pos];
  end

  always_ff @(posedge clk) begin
    if (ctl.tap_we) begin
      tap_mem[tap_addr] <= tap_data;
    end
    tap_q <= tap_mem[cnt[AW-1:0]];
  end

  assign sum = acc;

endmodule

[verif/tb_pd_fir_shaped_rate.sv]
// ----------------------------------------------------------------------------
// tb_pd_fir_shaped_rate
// Self-checking bench for the shaped PD rate law. A predictor in the bench
// follows every accepted request and queues the rate it should produce; each
// response is compared field by field. Directed requests cover the extremes,
// then random traffic runs in phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pd_fir_shaped_rate;
  import pdfs_pkg::*;

  localparam int          TAP_SLOTS    = 64;
  localparam int          SETTLE_WAIT  = 100;
  localparam int          PHASE_ITEMS  = 110;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam longint      PD_MAX       = 64'sd2147483647;
  localparam longint      PD_MIN       = -64'sd2147483648;
  localparam logic [30:0] LIMIT_MAX    = 31'h7FFFFFFF;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  req_t                req       = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  rsp_t                rsp;
  logic                cfg_we    = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data  = '0;

  int idle_pct;
  int stall_pct;
  int fail_count;

  // predictor state
  logic signed [23:0] kp;
  logic signed [23:0] kd;
  logic [30:0]        rate_lim;
  logic [6:0]         taps_len;
  logic signed [31:0] prev_err;
  logic               primed_q;
  logic signed [31:0] pd_hist [TAP_SLOTS];
  int                 hist_head;
  int                 hist_fill;
  logic signed [15:0] kernel [TAP_SLOTS];

  rsp_t pending_rates [$];

  pd_fir_shaped_rate dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    rsp_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  function automatic void clear_history();
    for (int i = 0; i < TAP_SLOTS; i++) pd_hist[i] = '0;
    hist_head = 0;
    hist_fill = 0;
  endfunction

  function automatic rsp_t shape_sample(logic signed [31:0] e);
    longint ee;
    longint diff;
    longint acc;
    longint pd;
    longint sum;
    longint v;
    longint lim;
    int     n;
    int     pos;
    rsp_t   r;
    ee = e;
    if (!primed_q) begin
      prev_err = e;
      primed_q = 1'b1;
    end
    diff = ee - longint'(prev_err);
    prev_err = e;
    acc = longint'(kp) * ee + longint'(kd) * diff;
    pd = acc >>> 16;
    if (pd > PD_MAX) pd = PD_MAX;
    if (pd < PD_MIN) pd = PD_MIN;

    // zero length acts as one, anything past the ring size as the full ring
    n = (taps_len == 0) ? 1 : ((taps_len > TAP_SLOTS) ? TAP_SLOTS : int'(taps_len));
    if (hist_head >= n) hist_head = 0;
    pd_hist[hist_head] = pd[31:0];
    hist_head = (hist_head + 1) % n;
    if (hist_fill < n) hist_fill++;
    if (hist_fill > n) hist_fill = n;

    // tap 0 sits on the newest entry
    sum = 0;
    for (int i = 0; i < hist_fill; i++) begin
      pos = (hist_head + n - 1 - i) % n;
      sum += longint'(pd_hist[pos]) * longint'(kernel[i]);
    end
    v = sum >>> 14;
    lim = rate_lim;
    r.clamped = 1'b0;
    if (v > lim) begin
      v = lim;
      r.clamped = 1'b1;
    end else if (v < -lim) begin
      v = -lim;
      r.clamped = 1'b1;
    end
    r.rate_out = v[31:0];
    return r;
  endfunction

  function automatic req_t make_request(logic [1:0] cmd, logic signed [31:0] err,
                                        logic [5:0] idx, logic signed [15:0] val);
    req_t r;
    r.command   = cmd;
    r.error_in  = err;
    r.tap_index = idx;
    r.tap_value = val;
    return r;
  endfunction

  task automatic report_error(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%t mismatch: %s", $realtime, msg);
  endtask

  // response checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rates.size() == 0) begin
        report_error($sformatf("response with nothing pending: rate %0d clamped %0b",
                               rsp.rate_out, rsp.clamped));
      end else begin
        want = pending_rates.pop_front();
        if (rsp.rate_out !== want.rate_out)
          report_error($sformatf("rate_out expected %0d got %0d",
                                 want.rate_out, rsp.rate_out));
        if (rsp.clamped !== want.clamped)
          report_error($sformatf("clamped expected %0b got %0b",
                                 want.clamped, rsp.clamped));
      end
    end
  end

  task automatic send_request(req_t r);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    case (r.command)
      CMD_SAMPLE:  pending_rates.push_back(shape_sample(r.error_in));
      CMD_TAP:     kernel[r.tap_index] = r.tap_value;
      CMD_RESTART: begin
        prev_err = '0;
        primed_q = 1'b0;
        clear_history();
      end
      default: ;
    endcase
  endtask

  task automatic send_sample(logic signed [31:0] e);
    send_request(make_request(CMD_SAMPLE, e, 6'($urandom), 16'($urandom)));
  endtask

  // drain responses, then give the block time to finish a request with no response
  task automatic settle();
    req_valid <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] index, logic [30:0] value);
    logic [30:0] data;
    data = value;
    // unused upper bits get random content
    case (index)
      REG_PGAIN, REG_DGAIN: data[30:24] = 7'($urandom);
      REG_TAPS:             data[30:7]  = 24'($urandom);
      default: ;
    endcase
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    case (index)
      REG_PGAIN: kp = data[23:0];
      REG_DGAIN: kd = data[23:0];
      REG_LIMIT: rate_lim = data;
      REG_TAPS: begin
        taps_len = data[6:0];
        clear_history();
      end
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_error();
    case ($urandom_range(4))
      0: return 32'($urandom);
      1: return 32'(int'($urandom_range(0, 1048576)) - 524288);
      2: return 32'(int'($urandom_range(0, 33554432)) - 16777216);
      3: case ($urandom_range(4))
           0: return 32'sh7FFFFFFF;
           1: return 32'sh80000000;
           2: return 32'sd0;
           3: return -32'sd1;
           default: return 32'sd1;
         endcase
      default: return 32'(int'($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  function automatic logic [23:0] rand_gain();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'sd0;
      default: return 24'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_tap(int mode);
    if (mode == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 4096)) - 2048);
  endfunction

  task automatic load_kernel(int mode);
    for (int i = 0; i < TAP_SLOTS; i++)
      send_request(make_request(CMD_TAP, 32'($urandom), 6'(i), rand_tap(mode)));
  endtask

  // every tap gets a value before any sample reads it
  task automatic test_kernel_load();
    idle_pct  = 26;
    stall_pct = 26;
    load_kernel(0);
    send_request(make_request(CMD_TAP, 32'($urandom), 6'd0, 16'sd16384));
    send_request(make_request(CMD_TAP, 32'($urandom), 6'd1, -16'sd32768));
    send_request(make_request(CMD_TAP, 32'($urandom), 6'd2, 16'sd32767));
    send_request(make_request(CMD_TAP, 32'($urandom), 6'd63, 16'sd0));
  endtask

  task automatic test_extremes();
    idle_pct  = 0;
    stall_pct = 0;
    settle();
    write_register(REG_PGAIN, 31'd65536);
    write_register(REG_DGAIN, 31'd0);
    write_register(REG_LIMIT, LIMIT_MAX);
    write_register(REG_TAPS, 31'd1);
    send_sample(32'sh7FFFFFFF);
    send_sample(32'sh80000000);
    send_sample(32'sd0);
    send_sample(-32'sd1);
    send_sample(32'sd1);
    settle();
    // largest gains of opposite sign push the PD term into saturation both ways
    write_register(REG_PGAIN, 31'h7FFFFF);
    write_register(REG_DGAIN, 31'h800000);
    write_register(REG_TAPS, 31'd3);
    send_sample(32'sh7FFFFFFF);
    send_sample(32'sh80000000);
    send_sample(32'sh7FFFFFFF);
    // first sample after a restart carries no difference
    send_request(make_request(CMD_RESTART, 32'($urandom), 6'($urandom), 16'($urandom)));
    send_sample(32'sh80000000);
    send_request(make_request(CMD_UNUSED, 32'($urandom), 6'($urandom), 16'($urandom)));
    send_sample(32'sd12345);
    settle();
    write_register(REG_LIMIT, 31'd0);
    send_sample(32'sd196608);
    send_sample(32'sd0);
    settle();
    write_register(REG_LIMIT, 31'd65536);
  endtask

  task automatic test_length_edges();
    idle_pct  = 26;
    stall_pct = 26;
    settle();
    write_register(REG_PGAIN, 31'd65536);
    write_register(REG_DGAIN, 31'd16384);
    write_register(REG_LIMIT, LIMIT_MAX);
    write_register(REG_TAPS, 31'd0);
    repeat (3) send_sample(rand_error());
    settle();
    write_register(REG_TAPS, 31'd127);
    repeat (3) send_sample(rand_error());
    settle();
    // rewriting the same length still empties the history
    write_register(REG_TAPS, 31'd127);
    repeat (2) send_sample(rand_error());
  endtask

  task automatic random_setting(int p);
    logic [30:0] lim;
    logic [6:0]  len;
    case (p)
      0: lim = LIMIT_MAX;
      1: lim = 31'd0;
      default: case ($urandom_range(2))
                 0: lim = 31'($urandom);
                 1: lim = 31'($urandom_range(65536, 4194304));
                 default: lim = 31'($urandom_range(0, 1048576));
               endcase
    endcase
    case (p)
      0: len = 7'd64;
      1: len = 7'd1;
      3: len = 7'd127;
      5: len = 7'($urandom_range(65, 126));
      6: len = 7'd0;
      default: len = 7'($urandom_range(2, 64));
    endcase
    write_register(REG_PGAIN, 31'(rand_gain()));
    write_register(REG_DGAIN, 31'(rand_gain()));
    write_register(REG_LIMIT, lim);
    write_register(REG_TAPS, 31'(len));
  endtask

  task automatic test_random_traffic();
    int counted;
    int pick;
    for (int p = 0; p < 8; p++) begin
      settle();
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      random_setting(p);
      if (p % 3 == 1) load_kernel(1);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 82) begin
          send_sample(rand_error());
          counted++;
        end else if (pick < 90) begin
          send_request(make_request(CMD_TAP, 32'($urandom), 6'($urandom),
                                    rand_tap($urandom_range(1))));
          counted++;
        end else if (pick < 95) begin
          send_request(make_request(CMD_RESTART, 32'($urandom), 6'($urandom),
                                    16'($urandom)));
          counted++;
        end else begin
          send_request(make_request(CMD_UNUSED, 32'($urandom), 6'($urandom),
                                    16'($urandom)));
        end
      end
    end
  endtask

  initial begin
    #6000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    idle_pct   = 0;
    stall_pct  = 0;
    fail_count = 0;
    kp         = '0;
    kd         = '0;
    rate_lim   = LIMIT_RESET;
    taps_len   = TAPS_RESET;
    prev_err   = '0;
    primed_q   = 1'b0;
    clear_history();
    for (int i = 0; i < TAP_SLOTS; i++) kernel[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_kernel_load();
    test_extremes();
    test_length_edges();
    test_random_traffic();

    settle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
